### rtl/lpm_pkg.sv
// ----------------------------------------------------------------------------
// lpm_pkg
// Shared types and constants for the longest-prefix-match route table:
// request and response payloads, operation codes and parameter defaults.
// ----------------------------------------------------------------------------
package lpm_pkg;

   // parameter defaults
   localparam int NUM_ROUTES_DEFAULT = 16;
   localparam int PORT_BITS_DEFAULT  = 4;

   // fixed field widths
   localparam int ADDR_W   = 32;
   localparam int INDEX_W  = 4;
   localparam int PORT_W   = 4;

   // operation codes
   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_LOOKUP = 1'b1
   } op_type;

   // request payload
   typedef struct packed {
      op_type              op;
      logic [INDEX_W-1:0]  entry_index;
      logic                entry_valid;
      logic [ADDR_W-1:0]   entry_prefix;
      logic [ADDR_W-1:0]   entry_netmask;
      logic [PORT_W-1:0]   entry_port;
      logic [ADDR_W-1:0]   lookup_addr;
   } req_type;

   // response payload
   typedef struct packed {
      logic                found;
      logic [PORT_W-1:0]   out_port;
      logic [ADDR_W-1:0]   best_netmask;
   } rsp_type;

endpackage

### rtl/lpm_table.sv
// ----------------------------------------------------------------------------
// lpm_table
// Route entry storage with one write port, plus the per-entry match stage
// that registers a hit flag, mask and port for every leaf of the select tree.
// ----------------------------------------------------------------------------
module lpm_table
   import lpm_pkg::*;
#(
   parameter int NUM_ROUTES = NUM_ROUTES_DEFAULT,
   parameter int PORT_BITS  = PORT_BITS_DEFAULT,
   parameter int LEAVES     = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // write port
   input  logic                                wr_en,
   input  logic [INDEX_W-1:0]                  wr_index,
   input  logic                                wr_valid,
   input  logic [ADDR_W-1:0]                   wr_prefix,
   input  logic [ADDR_W-1:0]                   wr_netmask,
   input  logic [PORT_W-1:0]                   wr_port,
   // lookup side
   input  logic                                lk_lookup,
   input  logic [ADDR_W-1:0]                   lk_addr,
   input  logic                                leaf_load,
   output logic [LEAVES-1:0]                   leaf_hit,
   output logic [LEAVES-1:0][ADDR_W-1:0]       leaf_mask,
   output logic [LEAVES-1:0][PORT_BITS-1:0]    leaf_port
);

   logic [NUM_ROUTES-1:0]                 valid_ff;
   logic [NUM_ROUTES-1:0][ADDR_W-1:0]     prefix_ff;
   logic [NUM_ROUTES-1:0][ADDR_W-1:0]     netmask_ff;
   logic [NUM_ROUTES-1:0][PORT_BITS-1:0]  port_ff;

   logic [LEAVES-1:0]                     hit_in;
   logic [LEAVES-1:0]                     hit_ff;
   logic [LEAVES-1:0][ADDR_W-1:0]         mask_ff;
   logic [LEAVES-1:0][PORT_BITS-1:0]      lport_ff;

   genvar k;

   // entry storage, one slot selected by the write index
   for (k = 0; k < NUM_ROUTES; k++) begin : g_entry
      logic sel;
      assign sel = wr_en && (9'(wr_index) == 9'(k));

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (sel) begin
            valid_ff[k] <= wr_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (sel) begin
            prefix_ff[k]  <= wr_prefix;
            netmask_ff[k] <= wr_netmask;
            port_ff[k]    <= PORT_BITS'(wr_port);
         end
      end
   end

   // per-entry match, padding leaves never hit
   for (k = 0; k < LEAVES; k++) begin : g_leaf
      if (k < NUM_ROUTES) begin : g_real
         assign hit_in[k] = lk_lookup && valid_ff[k] &&
                            ((lk_addr & netmask_ff[k]) == prefix_ff[k]);
         always_ff @(posedge clock) begin
            if (leaf_load) begin
               mask_ff[k]  <= hit_in[k] ? netmask_ff[k] : '0;
               lport_ff[k] <= hit_in[k] ? port_ff[k] : '0;
            end
         end
      end else begin : g_pad
         assign hit_in[k] = 1'b0;
         always_ff @(posedge clock) begin
            if (leaf_load) begin
               mask_ff[k]  <= '0;
               lport_ff[k] <= '0;
            end
         end
      end
   end

   // leaf hit flags
   always_ff @(posedge clock) begin
      if (leaf_load) begin
         hit_ff <= hit_in;
      end
   end

   assign leaf_hit  = hit_ff;
   assign leaf_mask = mask_ff;
   assign leaf_port = lport_ff;

endmodule

### rtl/lpm_tree.sv
// ----------------------------------------------------------------------------
// lpm_tree
// Registered binary select tree over the leaf matches, one tree level per
// pipeline stage, with valid bits and per-stage ready for stall handling.
// ----------------------------------------------------------------------------
module lpm_tree
   import lpm_pkg::*;
#(
   parameter int LEVELS    = 4,
   parameter int PORT_BITS = PORT_BITS_DEFAULT,
   parameter int LEAVES    = 2 ** LEVELS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [LEAVES-1:0]                   leaf_hit,
   input  logic [LEAVES-1:0][ADDR_W-1:0]       leaf_mask,
   input  logic [LEAVES-1:0][PORT_BITS-1:0]    leaf_port,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic                                out_hit,
   output logic [ADDR_W-1:0]                   out_mask,
   output logic [PORT_BITS-1:0]                out_port
);

   // stage d holds tree depth d; depth LEVELS is the leaf stage
   logic [LEVELS:0] vld_ff;
   logic [LEVELS:0] vld_in;
   logic [LEVELS:0] rdy;

   // heap-ordered nodes: 1 is the root, leaves sit at LEAVES..2*LEAVES-1
   logic                  node_hit  [1:2*LEAVES-1];
   logic [ADDR_W-1:0]     node_mask [1:2*LEAVES-1];
   logic [PORT_BITS-1:0]  node_port [1:2*LEAVES-1];

   genvar i;

   // ready chain, from the output back to the leaves
   always_comb begin
      rdy[0]    = !vld_ff[0] || out_ready;
      vld_in[0] = vld_ff[1];
      for (int d = 1; d <= LEVELS; d++) begin
         rdy[d]    = !vld_ff[d] || rdy[d-1];
         vld_in[d] = (d == LEVELS) ? in_valid : vld_ff[(d < LEVELS) ? d + 1 : d];
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int d = 0; d <= LEVELS; d++) begin
            if (rdy[d]) begin
               vld_ff[d] <= vld_in[d];
            end
         end
      end
   end

   // leaves come straight from the match registers
   for (i = 0; i < LEAVES; i++) begin : g_leaf
      assign node_hit[LEAVES+i]  = leaf_hit[i];
      assign node_mask[LEAVES+i] = leaf_mask[i];
      assign node_port[LEAVES+i] = leaf_port[i];
   end

   // inner nodes: right child wins on a hit with a longer mask, or when
   // the left side has no nonzero mask yet
   for (i = 1; i < LEAVES; i++) begin : g_node
      localparam int D = $clog2(i + 1) - 1;
      logic                  hit_ff;
      logic [ADDR_W-1:0]     mask_ff;
      logic [PORT_BITS-1:0]  port_ff;
      logic                  pick_right;

      assign pick_right = node_hit[2*i+1] &&
                          ((node_mask[2*i] == '0) || (node_mask[2*i+1] > node_mask[2*i]));

      always_ff @(posedge clock) begin
         if (rdy[D]) begin
            hit_ff  <= node_hit[2*i] || node_hit[2*i+1];
            mask_ff <= pick_right ? node_mask[2*i+1] : node_mask[2*i];
            port_ff <= pick_right ? node_port[2*i+1] : node_port[2*i];
         end
      end

      assign node_hit[i]  = hit_ff;
      assign node_mask[i] = mask_ff;
      assign node_port[i] = port_ff;
   end

   assign in_ready  = rdy[LEVELS];
   assign out_valid = vld_ff[0];
   assign out_hit   = node_hit[1];
   assign out_mask  = node_mask[1];
   assign out_port  = node_port[1];

endmodule

### rtl/route_longest_prefix_match.sv
// ----------------------------------------------------------------------------
// route_longest_prefix_match
// IPv4 route table with longest-prefix-match lookup.
//
// Requests arrive on req_valid/req_ready with a req_type payload. A write
// request (op OP_WRITE) loads one route slot; a lookup request (op OP_LOOKUP)
// matches lookup_addr against every valid slot. Each request gives exactly
// one response on rsp_valid/rsp_ready; writes answer with all fields zero.
//
// Throughput: one request per cycle while rsp_ready is high. The pipeline
// has log2(NUM_ROUTES) + 2 register stages: an input register, a match
// register per slot, then one stage per level of the binary select tree.
// Writes take effect at acceptance and are seen by every later lookup.
//
// Reset clears all route valid marks and empties the pipeline; slot contents
// are loaded only by writes. When the receiver holds rsp_ready low, stages
// keep filling bubbles and req_ready drops once every stage holds a request;
// nothing is lost or repeated.
// ----------------------------------------------------------------------------
module route_longest_prefix_match
   import lpm_pkg::*;
#(
   parameter int NUM_ROUTES = NUM_ROUTES_DEFAULT,
   parameter int PORT_BITS  = PORT_BITS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   localparam int LEVELS = (NUM_ROUTES > 1) ? $clog2(NUM_ROUTES) : 1;
   localparam int LEAVES = 2 ** LEVELS;

   logic                  a_vld_ff;
   logic                  a_lookup_ff;
   logic [ADDR_W-1:0]     a_addr_ff;
   logic                  a_ready;
   logic                  req_accept;
   logic                  wr_en;
   logic                  leaf_load;

   logic [LEAVES-1:0]                  leaf_hit;
   logic [LEAVES-1:0][ADDR_W-1:0]      leaf_mask;
   logic [LEAVES-1:0][PORT_BITS-1:0]   leaf_port;

   logic                  root_hit;
   logic [ADDR_W-1:0]     root_mask;
   logic [PORT_BITS-1:0]  root_port;

   // input stage
   assign a_ready    = !a_vld_ff || leaf_load;
   assign req_ready  = a_ready;
   assign req_accept = req_valid && a_ready;
   assign wr_en      = req_accept && (req_data.op == OP_WRITE);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (a_ready) begin
         a_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_lookup_ff <= (req_data.op == OP_LOOKUP);
         a_addr_ff   <= req_data.lookup_addr;
      end
   end

   // route storage and per-slot match
   lpm_table #(
      .NUM_ROUTES (NUM_ROUTES),
      .PORT_BITS  (PORT_BITS),
      .LEAVES     (LEAVES)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_index   (req_data.entry_index),
      .wr_valid   (req_data.entry_valid),
      .wr_prefix  (req_data.entry_prefix),
      .wr_netmask (req_data.entry_netmask),
      .wr_port    (req_data.entry_port),
      .lk_lookup  (a_lookup_ff),
      .lk_addr    (a_addr_ff),
      .leaf_load  (leaf_load),
      .leaf_hit   (leaf_hit),
      .leaf_mask  (leaf_mask),
      .leaf_port  (leaf_port)
   );

   // select tree
   lpm_tree #(
      .LEVELS    (LEVELS),
      .PORT_BITS (PORT_BITS),
      .LEAVES    (LEAVES)
   ) u_tree (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_vld_ff),
      .in_ready  (leaf_load),
      .leaf_hit  (leaf_hit),
      .leaf_mask (leaf_mask),
      .leaf_port (leaf_port),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_hit   (root_hit),
      .out_mask  (root_mask),
      .out_port  (root_port)
   );

   // response fields
   always_comb begin
      rsp_data.found        = root_hit;
      rsp_data.out_port     = PORT_W'(root_port);
      rsp_data.best_netmask = root_mask;
   end

endmodule

### rtl/lpm_checker.sv
// ----------------------------------------------------------------------------
// lpm_checker
// Port-level checks for the route table: response hold under stall, zeroed
// fields on a miss, empty pipeline after reset, no response without a
// pending request.
// ----------------------------------------------------------------------------
module lpm_checker
   import lpm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_ready,
   input  logic     rsp_valid,
   input  logic     rsp_ready,
   input  rsp_type  rsp_data
);

   logic [9:0] pending_ff;
   logic [9:0] pending_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // requests accepted but not yet answered
   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + 10'd1;
      end else if (rsp_fire && !req_fire) begin
         pending_in = pending_ff - 10'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // a miss reports zero port and mask
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.out_port == '0 &&
                                         rsp_data.best_netmask == '0)
      else $error("miss with nonzero port or mask");

   // pipeline is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // every response answers an accepted request
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("response without a pending request");

endmodule

bind route_longest_prefix_match lpm_checker u_lpm_checker (.*);

### dv/route_longest_prefix_match_tb.sv
// ----------------------------------------------------------------------------
// route_longest_prefix_match_tb
// Self-checking bench for the longest-prefix-match route table. A directed
// table covers reset state, zero-mask routes, equal masks, removal and mask
// extremes. Random route writes and lookups follow, mostly lookups aimed at
// stored prefixes. Every accepted request is run through a local route table
// model and the response is compared field by field, in order. Both
// handshakes see random gaps, with stretches of full rate.
// ----------------------------------------------------------------------------
module route_longest_prefix_match_tb
   import lpm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_ROUTES      = NUM_ROUTES_DEFAULT;
   localparam int RANDOM_REQUESTS = 1550;
   localparam int DRAIN_CYCLES    = 12;
   localparam int DIR_ROWS        = 25;
   localparam rsp_type RSP_ZERO   = '0;

   // directed row: request, whether the response is typed in, typed response
   typedef struct packed {
      req_type req;
      logic    typed;
      rsp_type rsp;
   } dir_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // local copy of the route table
   bit              tbl_valid   [NUM_ROUTES];
   bit [ADDR_W-1:0] tbl_prefix  [NUM_ROUTES];
   bit [ADDR_W-1:0] tbl_netmask [NUM_ROUTES];
   bit [PORT_W-1:0] tbl_port    [NUM_ROUTES];

   rsp_type pending_rsp_q [$];
   int      mismatch_count = 0;
   int      stall_left     = 0;
   bit      quiet_phase    = 1'b0;

   // directed stimulus: lookups leave entry fields zero, writes the address
   dir_row_type dir_table [DIR_ROWS] = '{
      '{'{OP_LOOKUP, 4'd0,  1'b0, 32'h0000_0000, 32'h0000_0000, 4'd0,  32'h0000_0000},
        1'b1, RSP_ZERO},
      '{'{OP_LOOKUP, 4'd0,  1'b0, 32'h0000_0000, 32'h0000_0000, 4'd0,  32'hFFFF_FFFF},
        1'b1, RSP_ZERO},
      '{'{OP_WRITE,  4'd0,  1'b1, 32'h0000_0000, 32'h0000_0000, 4'd3,  32'h0000_0000},
        1'b1, RSP_ZERO},
      '{'{OP_LOOKUP, 4'd0,  1'b0, 32'h0000_0000, 32'h0000_0000, 4'd0,  32'h1234_5678},
        1'b1, '{1'b1, 4'd3, 32'h0000_0000}},
      '{'{OP_WRITE,  4'd15, 1'b1, 32'h0000_0000, 32'h0000_0000, 4'd12, 32'h0000_0000},
        1'b1, RSP_ZERO},
      // two zero-mask routes match: the later one wins
      '{'{OP_LOOKUP, 4'd0,  1'b0, 32'h0000_0000, 32'h0000_0000, 4'd0,  32'hDEAD_BEEF},
        1'b1, '{1'b1, 4'd12, 32'h0000_0000}},
      '{'{OP_WRITE,  4'd1,  1'b1, 32'h0A00_0000, 32'hFF00_0000, 4'd1,  32'h0000_0000},
        1'b0, RSP_ZERO},
      '{'{OP_WRITE,  4'd2,  1'b1, 32'h0A01_0000, 32'hFFFF_0000, 4'd2,  32'h0000_0000},
        1'b0, RSP_ZERO},
      // same mask as slot 2 at a later slot must not take over
      '{'{OP_WRITE,  4'd3,  1'b1, 32'h0A01_0000, 32'hFFFF_0000, 4'd5,  32'h0000_0000},
        1'b0, RSP_ZERO},
      '{'{OP_LOOKUP, 4'd0,  1'b0, 32'h0000_0000, 32'h0000_0000, 4'd0,  32'h0A01_0203},
        1'b0, RSP_ZERO},
      '{'{OP_LOOKUP, 4'd0,  1'b0, 32'h0000_0000, 32'h0000_0000, 4'd0,  32'h0A02_0304},
        1'b0, RSP_ZERO},
      '{'{OP_WRITE,  4'd4,  1'b1, 32'hC0A8_0101, 32'hFFFF_FFFF, 4'd15, 32'h0000_0000},
        1'b1, RSP_ZERO},
      '{'{OP_LOOKUP, 4'd0,  1'b0, 32'h0000_0000, 32'h0000_0000, 4'd0,  32'hC0A8_0101},
        1'b1, '{1'b1, 4'd15, 32'hFFFF_FFFF}},
      '{'{OP_LOOKUP, 4'd0,  1'b0, 32'h0000_0000, 32'h0000_0000, 4'd0,  32'hC0A8_0100},
        1'b0, RSP_ZERO},
      // host route removed again
      '{'{OP_WRITE,  4'd4,  1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0,  32'h0000_0000},
        1'b0, RSP_ZERO},
      '{'{OP_LOOKUP, 4'd0,  1'b0, 32'h0000_0000, 32'h0000_0000, 4'd0,  32'hC0A8_0101},
        1'b0, RSP_ZERO},
      '{'{OP_WRITE,  4'd7,  1'b1, 32'h8000_0000, 32'h8000_0000, 4'd9,  32'h0000_0000},
        1'b0, RSP_ZERO},
      '{'{OP_LOOKUP, 4'd0,  1'b0, 32'h0000_0000, 32'h0000_0000, 4'd0,  32'hFFFF_FFFF},
        1'b0, RSP_ZERO},
      '{'{OP_WRITE,  4'd0,  1'b0, 32'h0000_0000, 32'h0000_0000, 4'd0,  32'h0000_0000},
        1'b0, RSP_ZERO},
      '{'{OP_WRITE,  4'd15, 1'b0, 32'h0000_0000, 32'h0000_0000, 4'd0,  32'h0000_0000},
        1'b0, RSP_ZERO},
      '{'{OP_LOOKUP, 4'd0,  1'b0, 32'h0000_0000, 32'h0000_0000, 4'd0,  32'h0102_0304},
        1'b0, RSP_ZERO},
      '{'{OP_WRITE,  4'd8,  1'b1, 32'h0A01_0200, 32'hFFFF_FF00, 4'd6,  32'h0000_0000},
        1'b0, RSP_ZERO},
      // prefix with host bits set can never match
      '{'{OP_WRITE,  4'd9,  1'b1, 32'h0A01_02FF, 32'hFFFF_FF00, 4'd7,  32'h0000_0000},
        1'b0, RSP_ZERO},
      '{'{OP_LOOKUP, 4'd0,  1'b0, 32'h0000_0000, 32'h0000_0000, 4'd0,  32'h0A01_02FF},
        1'b0, RSP_ZERO},
      '{'{OP_LOOKUP, 4'd0,  1'b0, 32'h0000_0000, 32'h0000_0000, 4'd0,  32'h0A01_02FE},
        1'b0, RSP_ZERO}
   };

   route_longest_prefix_match u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // run limit
   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // apply one request to the local table and return its response
   function automatic rsp_type route_table_apply(input req_type r);
      rsp_type         res;
      bit [ADDR_W-1:0] best;
      res  = '0;
      best = '0;
      if (r.op == OP_WRITE) begin
         if (r.entry_index < NUM_ROUTES) begin
            tbl_valid[r.entry_index]   = r.entry_valid;
            tbl_prefix[r.entry_index]  = r.entry_prefix;
            tbl_netmask[r.entry_index] = r.entry_netmask;
            tbl_port[r.entry_index]    = r.entry_port;
         end
      end else begin
         // scan in slot order, a zero best mask can always be replaced
         for (int k = 0; k < NUM_ROUTES; k++) begin
            if (tbl_valid[k] && (tbl_netmask[k] > best || best == '0) &&
                (r.lookup_addr & tbl_netmask[k]) == tbl_prefix[k]) begin
               res.found    = 1'b1;
               res.out_port = tbl_port[k];
               best         = tbl_netmask[k];
            end
         end
         res.best_netmask = best;
      end
      return res;
   endfunction

   // idle length: mostly short, a few long
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      else if (r < 95) return $urandom_range(4, 10);
      else return $urandom_range(20, 60);
   endfunction

   // random request: prefix-shaped routes, lookups aimed at stored routes
   function automatic req_type make_route_request();
      req_type         r;
      int              sel;
      int              len;
      int              k;
      bit [ADDR_W-1:0] m;
      r   = '0;
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
         r.op          = OP_WRITE;
         r.entry_index = INDEX_W'($urandom_range(0, NUM_ROUTES - 1));
         r.entry_valid = ($urandom_range(0, 99) < 85);
         r.entry_port  = PORT_W'($urandom);
         r.lookup_addr = $urandom;
         sel = $urandom_range(0, 99);
         if (sel < 8) begin
            m = '0;
         end else if (sel < 20) begin
            m = $urandom;
         end else begin
            len = (sel < 45) ? 8 * $urandom_range(1, 4) : $urandom_range(1, 32);
            m   = 32'hFFFF_FFFF << (32 - len);
         end
         r.entry_netmask = m;
         r.entry_prefix  = ($urandom_range(0, 99) < 85) ? ($urandom & m) : $urandom;
      end else begin
         r.op            = OP_LOOKUP;
         r.entry_index   = INDEX_W'($urandom);
         r.entry_valid   = 1'($urandom_range(0, 1));
         r.entry_prefix  = $urandom;
         r.entry_netmask = $urandom;
         r.entry_port    = PORT_W'($urandom);
         k   = $urandom_range(0, NUM_ROUTES - 1);
         m   = tbl_netmask[k];
         sel = $urandom_range(0, 99);
         if (sel < 55) begin
            r.lookup_addr = tbl_prefix[k] | ($urandom & ~m);
         end else if (sel < 70) begin
            // one bit off a stored route
            r.lookup_addr = (tbl_prefix[k] | ($urandom & ~m)) ^ (32'h1 << $urandom_range(0, 31));
         end else begin
            r.lookup_addr = $urandom;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      $display("%0t: %s: got %h, expected %h", $time, what, got, want);
   endtask

   // send one request, then record its expected response at acceptance
   task automatic send_request(input req_type r, input logic typed, input rsp_type rsp);
      int      gap;
      rsp_type predicted;
      gap = (!quiet_phase && $urandom_range(0, 99) < 25) ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      predicted = route_table_apply(r);
      pending_rsp_q.push_back(typed ? rsp : predicted);
   endtask

   // response check and receiver stalls
   always @(posedge clock) begin
      rsp_type head_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp_q.size() == 0) begin
            report_mismatch("response with no request pending", 64'(rsp_data), '0);
         end else begin
            head_rsp = pending_rsp_q.pop_front();
            if (rsp_data.found !== head_rsp.found)
               report_mismatch("found", 64'(rsp_data.found), 64'(head_rsp.found));
            if (rsp_data.out_port !== head_rsp.out_port)
               report_mismatch("out_port", 64'(rsp_data.out_port), 64'(head_rsp.out_port));
            if (rsp_data.best_netmask !== head_rsp.best_netmask)
               report_mismatch("best_netmask", 64'(rsp_data.best_netmask),
                               64'(head_rsp.best_netmask));
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 99) < 15) begin
         stall_left = idle_length() - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // reset, directed table, random requests, drain
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_table[i]) begin
         send_request(dir_table[i].req, dir_table[i].typed, dir_table[i].rsp);
      end
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         // every third stretch runs at full rate on both sides
         quiet_phase = ((n / 250) % 3 == 1);
         send_request(make_route_request(), 1'b0, RSP_ZERO);
      end
      quiet_phase = 1'b0;
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
